// ----- design/seg_pkg.sv -----
// ----------------------------------------------------------------------------
// seg_pkg
// Shared constants for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package seg_pkg;

    // Default coordinate width in bits, signed two's complement.
    localparam int COORD_WIDTH_DEF   = 16;

    // Default number of fraction bits of the crossing parameters.
    localparam int FRACTION_BITS_DEF = 16;

endpackage

// ----- design/segment_intersection.sv -----
// ----------------------------------------------------------------------------
// segment_intersection
// Pipelined proper-crossing test of two segments with Cramer's rule parameters.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one beat per segment pair P1-P2, Q1-Q2 (signed
//   coordinates). The m_ channel returns one beat per pair: hit, and the
//   crossing parameters along P and along Q as unsigned Q0.FRACTION_BITS
//   fractions truncated toward zero, or -1.0 (only the top bit set) on a miss.
//   Collinear, touching and zero-length cases count as a miss.
//   Throughput is one beat per cycle while no output beat is held:
//   differences, products, cross products and the side test take four stages,
//   then a restoring divider produces one quotient bit per stage.
//   The pipeline moves as a whole: when the output beat is held by m_ready low,
//   s_ready drops and every stage holds; bubbles in the pipe still move on
//   whenever the output stage is empty.
//   Reset (aresetn low, synchronous) empties every stage; no beat is pending
//   afterwards.
// ----------------------------------------------------------------------------
module segment_intersection #(
    parameter int COORD_WIDTH   = seg_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = seg_pkg::FRACTION_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [COORD_WIDTH-1:0]   s_p1_x,
    input  logic signed [COORD_WIDTH-1:0]   s_p1_y,
    input  logic signed [COORD_WIDTH-1:0]   s_p2_x,
    input  logic signed [COORD_WIDTH-1:0]   s_p2_y,
    input  logic signed [COORD_WIDTH-1:0]   s_q1_x,
    input  logic signed [COORD_WIDTH-1:0]   s_q1_y,
    input  logic signed [COORD_WIDTH-1:0]   s_q2_x,
    input  logic signed [COORD_WIDTH-1:0]   s_q2_y,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_hit,
    output logic signed [FRACTION_BITS:0]   m_lambda_first,
    output logic signed [FRACTION_BITS:0]   m_lambda_second
);

    localparam int DW = COORD_WIDTH + 1;       // difference width
    localparam int PW = 2 * DW;                // product width
    localparam int CW = PW + 1;                // cross product width
    localparam int RW = CW + 1;                // divider remainder width
    localparam int FB = FRACTION_BITS;

    // Pipeline advance: all stages move unless the output beat is held.
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ------------------------------------------------------------------
    // Stage 1: coordinate differences.
    // ------------------------------------------------------------------
    logic                 v1_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, ex_reg, ey_reg;
    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg, gx_reg, gy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg <= DW'(s_p2_x) - DW'(s_p1_x);
            dy_reg <= DW'(s_p2_y) - DW'(s_p1_y);
            ex_reg <= DW'(s_q2_x) - DW'(s_q1_x);
            ey_reg <= DW'(s_q2_y) - DW'(s_q1_y);
            ax_reg <= DW'(s_q1_x) - DW'(s_p1_x);
            ay_reg <= DW'(s_q1_y) - DW'(s_p1_y);
            bx_reg <= DW'(s_q2_x) - DW'(s_p1_x);
            by_reg <= DW'(s_q2_y) - DW'(s_p1_y);
            gx_reg <= DW'(s_p2_x) - DW'(s_q1_x);
            gy_reg <= DW'(s_p2_y) - DW'(s_q1_y);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the ten partial products of the five cross products.
    // ------------------------------------------------------------------
    logic                 v2_reg;
    logic signed [PW-1:0] m_p1a_reg, m_p1b_reg, m_p2a_reg, m_p2b_reg;
    logic signed [PW-1:0] m_xa_reg, m_xb_reg, m_q2a_reg, m_q2b_reg;
    logic signed [PW-1:0] m_da_reg, m_db_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_p1a_reg <= dx_reg * ay_reg;
            m_p1b_reg <= dy_reg * ax_reg;
            m_p2a_reg <= dx_reg * by_reg;
            m_p2b_reg <= dy_reg * bx_reg;
            m_xa_reg  <= ex_reg * ay_reg;
            m_xb_reg  <= ey_reg * ax_reg;
            m_q2a_reg <= ex_reg * gy_reg;
            m_q2b_reg <= ey_reg * gx_reg;
            m_da_reg  <= dx_reg * ey_reg;
            m_db_reg  <= dy_reg * ex_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: cross products. cp1 is also dety, cx is detx, and cd is
    // the negated determinant; the side of P1 from Q is the sign of -cx.
    // ------------------------------------------------------------------
    logic                 v3_reg;
    logic signed [CW-1:0] cp1_reg, cp2_reg, cx_reg, cq2_reg, cd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cp1_reg <= CW'(m_p1a_reg) - CW'(m_p1b_reg);
            cp2_reg <= CW'(m_p2a_reg) - CW'(m_p2b_reg);
            cx_reg  <= CW'(m_xa_reg)  - CW'(m_xb_reg);
            cq2_reg <= CW'(m_q2a_reg) - CW'(m_q2b_reg);
            cd_reg  <= CW'(m_da_reg)  - CW'(m_db_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: side tests and magnitudes for the divider. On a hit both
    // quotients lie strictly between 0 and 1, so only magnitudes matter.
    // ------------------------------------------------------------------
    logic p_ok, q_ok;
    assign p_ok = (cp1_reg != '0) && (cp2_reg != '0) && (cp1_reg[CW-1] != cp2_reg[CW-1]);
    assign q_ok = (cx_reg != '0) && (cq2_reg != '0) && (cx_reg[CW-1] == cq2_reg[CW-1]);

    logic          v_reg   [0:FB];
    logic          hit_reg [0:FB];
    logic [CW-1:0] den_reg [0:FB];
    logic [RW-1:0] ra_reg  [0:FB];
    logic [RW-1:0] rb_reg  [0:FB];
    logic [FB-1:0] qa_reg  [0:FB];
    logic [FB-1:0] qb_reg  [0:FB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg[0] <= p_ok && q_ok;
            den_reg[0] <= cd_reg[CW-1]  ? CW'(-cd_reg)  : CW'(cd_reg);
            ra_reg[0]  <= RW'(cx_reg[CW-1]  ? CW'(-cx_reg)  : CW'(cx_reg));
            rb_reg[0]  <= RW'(cp1_reg[CW-1] ? CW'(-cp1_reg) : CW'(cp1_reg));
            qa_reg[0]  <= '0;
            qb_reg[0]  <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: restoring division, one quotient bit per stage for
    // both parameters against the shared denominator.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < FB; k++) begin : g_div
        logic [RW-1:0] sa, sb;
        logic          ga, gb;

        assign sa = {ra_reg[k][RW-2:0], 1'b0};
        assign sb = {rb_reg[k][RW-2:0], 1'b0};
        assign ga = sa >= RW'(den_reg[k]);
        assign gb = sb >= RW'(den_reg[k]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (adv) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                hit_reg[k+1] <= hit_reg[k];
                den_reg[k+1] <= den_reg[k];
                ra_reg[k+1]  <= ga ? sa - RW'(den_reg[k]) : sa;
                rb_reg[k+1]  <= gb ? sb - RW'(den_reg[k]) : sb;
                qa_reg[k+1]  <= (qa_reg[k] << 1) | FB'(ga);
                qb_reg[k+1]  <= (qb_reg[k] << 1) | FB'(gb);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output beat: a miss reads as -1.0 on both parameters.
    // ------------------------------------------------------------------
    assign m_valid         = v_reg[FB];
    assign m_hit           = hit_reg[FB];
    assign m_lambda_first  = hit_reg[FB] ? {1'b0, qa_reg[FB]} : {1'b1, {FB{1'b0}}};
    assign m_lambda_second = hit_reg[FB] ? {1'b0, qb_reg[FB]} : {1'b1, {FB{1'b0}}};

endmodule

// ----- tb/segment_intersection_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_intersection_test
// Self-checking bench for the segment crossing pipeline. A directed table of
// corner cases is followed by random segment pairs, most of them built to
// cross. Every pair is predicted in the bench with exact 64-bit determinants
// and a long division. Each m_ beat is then compared with the oldest
// prediction. Both sides idle at random in several phases.
// ----------------------------------------------------------------------------
module segment_intersection_test;

    localparam int CW = seg_pkg::COORD_WIDTH_DEF;
    localparam int FB = seg_pkg::FRACTION_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1200;
    localparam logic [FB:0] MISS_LAMBDA = {1'b1, {FB{1'b0}}};

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
    } seg_pair_t;

    typedef struct packed {
        logic        hit;
        logic [FB:0] lam1;
        logic [FB:0] lam2;
    } crossing_t;

    typedef struct packed {
        seg_pair_t pair;
        logic      typed;
        crossing_t want;
    } table_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    coord_t s_p1_x = '0, s_p1_y = '0, s_p2_x = '0, s_p2_y = '0;
    coord_t s_q1_x = '0, s_q1_y = '0, s_q2_x = '0, s_q2_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_hit;
    logic signed [FB:0] m_lambda_first, m_lambda_second;

    crossing_t pending_crossings[$];
    int error_count = 0;
    int beats_in = 0, beats_out = 0, hits_seen = 0;
    int idle_pct_in = 0, stall_pct_out = 0;
    int quiet_cycles = 0;

    segment_intersection uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_p1_x(s_p1_x), .s_p1_y(s_p1_y), .s_p2_x(s_p2_x), .s_p2_y(s_p2_y),
        .s_q1_x(s_q1_x), .s_q1_y(s_q1_y), .s_q2_x(s_q2_x), .s_q2_y(s_q2_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_lambda_first(m_lambda_first), .m_lambda_second(m_lambda_second)
    );

    // Free-running 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sign of the 2D cross product a x b, computed exactly in 64 bits.
    function automatic int orient(longint ax, longint ay, longint bx, longint by);
        longint c;
        c = ax * by - ay * bx;
        return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
    endfunction

    // Signed quotient num/den as a FB-bit fraction, truncated and saturated.
    function automatic logic [FB:0] fraction_of(longint num, longint den);
        logic neg;
        longint n, d, rem, q;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        if (d == 0 || n >= d) begin
            q = longint'(1) << FB;
        end else begin
            q = 0;
            rem = n;
            for (int i = 0; i < FB; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= d) begin
                    rem = rem - d;
                    q = q | 1;
                end
            end
        end
        if (neg) return (FB+1)'(-q);
        if (q > (longint'(1) << FB) - 1) q = (longint'(1) << FB) - 1;
        return q[FB:0];
    endfunction

    // Proper crossing test and Cramer's rule parameters.
    function automatic crossing_t predict_crossing(seg_pair_t s);
        longint p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
        longint dx, dy, ex, ey, fx, fy, rx, ry;
        int sp1, sp2, sq1, sq2;
        crossing_t r;
        p1x = s.p1x; p1y = s.p1y; p2x = s.p2x; p2y = s.p2y;
        q1x = s.q1x; q1y = s.q1y; q2x = s.q2x; q2y = s.q2y;
        dx = p2x - p1x; dy = p2y - p1y;
        ex = q2x - q1x; ey = q2y - q1y;
        sp1 = orient(dx, dy, q1x - p1x, q1y - p1y);
        sp2 = orient(dx, dy, q2x - p1x, q2y - p1y);
        sq1 = orient(ex, ey, p1x - q1x, p1y - q1y);
        sq2 = orient(ex, ey, p2x - q1x, p2y - q1y);
        if (sp1 * sp2 < 0 && sq1 * sq2 < 0) begin
            fx = q1x - q2x; fy = q1y - q2y;
            rx = q1x - p1x; ry = q1y - p1y;
            r.hit = 1'b1;
            r.lam1 = fraction_of(rx * fy - ry * fx, dx * fy - dy * fx);
            r.lam2 = fraction_of(dx * ry - dy * rx, dx * fy - dy * fx);
        end else begin
            r.hit = 1'b0;
            r.lam1 = MISS_LAMBDA;
            r.lam2 = MISS_LAMBDA;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [FB:0] got, logic [FB:0] want);
        $display("MISMATCH beat %0d %s: got %h expected %h", beats_out, what, got, want);
        error_count++;
    endtask

    function automatic coord_t rand_coord();
        unique case ($urandom_range(0, 3))
            0: return coord_t'(int'($urandom_range(0, 15)) - 8);
            1: return coord_t'(int'($urandom_range(0, 2047)) - 1024);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Random pair; mostly built around a shared point so that hits are common.
    function automatic seg_pair_t rand_pair();
        seg_pair_t s;
        int cx, cy, span;
        s = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        if ($urandom_range(0, 99) < 70) begin
            span = ($urandom_range(0, 3) == 0) ? 16000 : 300;
            cx = int'($urandom_range(0, 2 * span)) - span;
            cy = int'($urandom_range(0, 2 * span)) - span;
            s.p1x = coord_t'(cx - int'($urandom_range(1, span)));
            s.p1y = coord_t'(cy + int'($urandom_range(0, 2 * span)) - span);
            s.p2x = coord_t'(2 * cx - int'(s.p1x));
            s.p2y = coord_t'(2 * cy - int'(s.p1y));
            s.q1x = coord_t'(cx + int'($urandom_range(0, 2 * span)) - span);
            s.q1y = coord_t'(cy - int'($urandom_range(1, span)));
            s.q2x = coord_t'(2 * cx - int'(s.q1x) + int'($urandom_range(0, 6)) - 3);
            s.q2y = coord_t'(2 * cy - int'(s.q1y) + int'($urandom_range(0, 6)) - 3);
        end
        return s;
    endfunction

    // Present one beat at the falling edge and wait for its acceptance.
    task automatic send_pair(seg_pair_t s);
        while ($urandom_range(0, 99) < idle_pct_in) @(negedge aclk);
        {s_p1_x, s_p1_y, s_p2_x, s_p2_y, s_q1_x, s_q1_y, s_q2_x, s_q2_y} = s;
        s_valid = 1'b1;
        pending_crossings.push_back(predict_crossing(s));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_in++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Receiver readiness changes at the falling edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct_out);
    end

    // Check result beats and run the watchdog.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_crossings.size() == 0) begin
                $display("MISMATCH beat %0d: result with nothing pending", beats_out);
                error_count++;
            end else begin
                crossing_t w;
                w = pending_crossings.pop_front();
                if (m_hit !== w.hit) report_mismatch("hit", m_hit, w.hit);
                if (m_lambda_first !== w.lam1)
                    report_mismatch("lambda_first", m_lambda_first, w.lam1);
                if (m_lambda_second !== w.lam2)
                    report_mismatch("lambda_second", m_lambda_second, w.lam2);
                if (w.hit) hits_seen++;
            end
            beats_out++;
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results pending", pending_crossings.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Directed rows: typed expectations only for obvious misses.
    localparam coord_t CMAX = coord_t'(32767);
    localparam coord_t CMIN = coord_t'(-32768);
    localparam crossing_t MISS = {1'b0, MISS_LAMBDA, MISS_LAMBDA};
    localparam int NROWS = 14;
    table_row_t directed_rows[NROWS] = '{
        // All zero: degenerate, no hit.
        '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, MISS},
        // Extreme diagonals of the full range cross at the center.
        '{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0, MISS},
        '{'{CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN}, 1'b0, MISS},
        // Simple cross near the origin.
        '{'{-4, 0, 4, 0, 0, -4, 0, 4}, 1'b0, MISS},
        // Off-center crossing.
        '{'{-3, 0, 9, 0, 1, -7, 1, 2}, 1'b0, MISS},
        // Endpoint touches the other segment: no hit.
        '{'{-4, 0, 4, 0, 0, 0, 0, 4}, 1'b1, MISS},
        // Collinear and overlapping: no hit.
        '{'{0, 0, 8, 8, 2, 2, 6, 6}, 1'b1, MISS},
        // Parallel, disjoint.
        '{'{0, 0, 8, 0, 0, 1, 8, 1}, 1'b1, MISS},
        // Zero-length second segment.
        '{'{-4, 0, 4, 0, 1, 0, 1, 0}, 1'b1, MISS},
        // Lines cross but the segments do not reach.
        '{'{0, 0, 1, 0, 5, -1, 5, 1}, 1'b1, MISS},
        // Steep crossing with large spans.
        '{'{CMIN, 0, CMAX, 1, 0, CMIN, 1, CMAX}, 1'b0, MISS},
        // Every coordinate bit at one, then only the sign bit, then all but the sign bit.
        '{'{-1, -1, -1, -1, -1, -1, -1, -1}, 1'b1, MISS},
        '{'{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, 1'b1, MISS},
        '{'{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b1, MISS}
    };

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table, no idling.
        for (int r = 0; r < NROWS; r++) begin
            if (directed_rows[r].typed &&
                predict_crossing(directed_rows[r].pair) !== directed_rows[r].want) begin
                $display("MISMATCH row %0d: predictor disagrees with table", r);
                error_count++;
            end
            send_pair(directed_rows[r].pair);
        end

        // Hold off until the pipe drains.
        while (pending_crossings.size() != 0) @(negedge aclk);

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct_in   = (ph == 1) ? 79 : ((ph == 3) ? 8 : 0);
            stall_pct_out = (ph == 2) ? 79 : ((ph == 3) ? 8 : 0);
            for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_pair(rand_pair());
        end

        stall_pct_out = 0;
        while (pending_crossings.size() != 0) @(negedge aclk);
        repeat (4 + FB + 10) @(negedge aclk);

        $display("Sent %0d segment pairs, checked %0d results, %0d of them crossings.",
                 beats_in, beats_out, hits_seen);
        $display("Idle patterns covered: none, sender idle, receiver stall, both.");
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
